// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the cushion rebound RTL.
// Each file that checks itself includes this header; a synthesis build
// defines SYNTHESIS and the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== hw/rtl/wrs_pkg.sv =====
// Types and constants for the cushion rebound block.
// Used by the register file, the per-axis pipeline and the top level.
`default_nettype none

package wrs_pkg;

  localparam int DATA_W      = 32;
  localparam int LEN_W       = 20;
  localparam int RADIUS_W    = 16;
  localparam int COEF_W      = 17;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TABLE_LENGTH      = 3'd0,
    REG_TABLE_WIDTH       = 3'd1,
    REG_RADIUS            = 3'd2,
    REG_BASE_RESTITUTION  = 3'd3,
    REG_SPEED_COEFFICIENT = 3'd4,
    REG_SPIN_TRANSFER     = 3'd5,
    REG_RAIL_FRICTION     = 3'd6
  } cfg_reg_t;

  localparam logic [17:0] E_FLOOR_Q16   = 18'd36045;
  localparam logic [15:0] SPIN_KEEP_Q16 = 16'd42598;
  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [17:0] TWO_Q16       = 18'd131072;

  localparam logic signed [DATA_W-1:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] INT32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [LEN_W-1:0]    table_length;
    logic [LEN_W-1:0]    table_width;
    logic [RADIUS_W-1:0] radius;
    logic [COEF_W-1:0]   base_restitution;
    logic [COEF_W-1:0]   speed_coefficient;
    logic [COEF_W-1:0]   spin_transfer;
    logic [COEF_W-1:0]   rail_friction;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    table_length:      20'd166461,
    table_width:       20'd83231,
    radius:            16'd1873,
    base_restitution:  17'd61000,
    speed_coefficient: 17'd1000,
    spin_transfer:     17'd655,
    rail_friction:     17'd13107
  };

  // Ball state seen from one axis: normal and tangential components.
  typedef struct packed {
    logic signed [DATA_W-1:0] pos_n;
    logic signed [DATA_W-1:0] pos_o;
    logic signed [DATA_W-1:0] vel_n;
    logic signed [DATA_W-1:0] vel_t;
    logic signed [DATA_W-1:0] spin;
    logic                     hit;
    logic                     sunk;
  } ball_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wrs_cfg.sv =====
// Configuration register file of the cushion rebound block.
// Depends on wrs_pkg for the register layout, indexes and reset values.
`default_nettype none

module wrs_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wrs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wrs_pkg::CFG_DATA_W-1:0]      cfg_data,
  output wrs_pkg::cfg_t                       regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= wrs_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wrs_pkg::REG_TABLE_LENGTH:      regs.table_length      <= cfg_data[19:0];
        wrs_pkg::REG_TABLE_WIDTH:       regs.table_width       <= cfg_data[19:0];
        wrs_pkg::REG_RADIUS:            regs.radius            <= cfg_data[15:0];
        wrs_pkg::REG_BASE_RESTITUTION:  regs.base_restitution  <= cfg_data[16:0];
        wrs_pkg::REG_SPEED_COEFFICIENT: regs.speed_coefficient <= cfg_data[16:0];
        wrs_pkg::REG_SPIN_TRANSFER:     regs.spin_transfer     <= cfg_data[16:0];
        wrs_pkg::REG_RAIL_FRICTION:     regs.rail_friction     <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wrs_axis.sv =====
// Four-stage cushion pipeline for one axis: wall test, restitution,
// rebound and spin products, then clamping and saturation.
// Depends on wrs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wrs_axis (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         spin_sub_low,
  input  logic [wrs_pkg::LEN_W-1:0]    limit,
  input  wrs_pkg::cfg_t                cfg,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  wrs_pkg::ball_t               up_ball,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output wrs_pkg::ball_t               dn_ball
);

  typedef struct packed {
    wrs_pkg::ball_t     ball;
    logic               lo;
    logic               hi;
    logic [31:0]        mag;
    logic               tbig;
    logic [15:0]        tlow;
    logic signed [32:0] shift;
  } stage_a_t;

  typedef struct packed {
    wrs_pkg::ball_t     ball;
    logic               lo;
    logic               hi;
    logic [31:0]        mag;
    logic               tbig;
    logic [17:0]        e;
    logic signed [33:0] tsum;
  } stage_b_t;

  typedef struct packed {
    wrs_pkg::ball_t     ball;
    logic               lo;
    logic               hi;
    logic [32:0]        mag2;
    logic signed [35:0] tnew;
  } stage_c_t;

  typedef struct packed {
    wrs_pkg::ball_t ball;
    logic           lo;
    logic           hi;
  } stage_d_t;

  logic     valid_a, valid_b, valid_c, valid_d;
  logic     ready_a, ready_b, ready_c, ready_d;
  stage_a_t stage_a, stage_a_next;
  stage_b_t stage_b, stage_b_next;
  stage_c_t stage_c, stage_c_next;
  stage_d_t stage_d, stage_d_next;

  logic signed [33:0] a_pos, a_low_gap, a_high_gap;
  logic [31:0]        a_mag;
  logic [48:0]        a_tprod;
  logic signed [49:0] a_sprod;
  logic signed [48:0] a_kprod;
  logic               a_lo, a_hi;

  logic [33:0]        b_escale;
  logic signed [33:0] b_vt, b_sh;
  logic               b_sub;

  logic [17:0]        c_efin;
  logic [49:0]        c_mprod;
  logic [17:0]        c_scale;
  logic signed [52:0] c_fprod;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return wrs_pkg::INT32_MAX;
    end else if (v < -36'sd2147483648) begin
      return wrs_pkg::INT32_MIN;
    end else begin
      return v[31:0];
    end
  endfunction

  assign ready_d  = !valid_d || dn_ready;
  assign ready_c  = !valid_c || ready_d;
  assign ready_b  = !valid_b || ready_c;
  assign ready_a  = !valid_a || ready_b;
  assign up_ready = ready_a;

  always_comb begin
    a_pos      = 34'(up_ball.pos_n);
    a_low_gap  = a_pos - $signed({18'b0, cfg.radius});
    a_high_gap = a_pos + $signed({18'b0, cfg.radius}) - $signed({14'b0, limit});
    a_lo       = !up_ball.sunk && a_low_gap[33] && up_ball.vel_n[31];
    a_hi       = !up_ball.sunk && !a_lo && !a_high_gap[33] && (a_high_gap != 34'sd0)
                 && !up_ball.vel_n[31] && (up_ball.vel_n != 32'sd0);
    a_mag      = up_ball.vel_n[31] ? (~up_ball.vel_n + 32'd1) : up_ball.vel_n;
    a_tprod    = 49'(a_mag) * 49'(cfg.speed_coefficient);
    a_sprod    = 50'(up_ball.spin) * $signed({33'b0, cfg.spin_transfer});
    a_kprod    = 49'(up_ball.spin) * $signed({33'b0, wrs_pkg::SPIN_KEEP_Q16});

    stage_a_next            = '0;
    stage_a_next.ball       = up_ball;
    stage_a_next.ball.spin  = (a_lo || a_hi) ? a_kprod[47:16] : up_ball.spin;
    stage_a_next.lo         = a_lo;
    stage_a_next.hi         = a_hi;
    stage_a_next.mag        = a_mag;
    stage_a_next.tbig       = |a_tprod[48:32];
    stage_a_next.tlow       = a_tprod[31:16];
    stage_a_next.shift      = a_sprod[48:16];
  end

  always_comb begin
    b_escale = 34'(cfg.base_restitution) * 34'(wrs_pkg::ONE_Q16 - {1'b0, stage_a.tlow});
    b_vt     = 34'(stage_a.ball.vel_t);
    b_sh     = 34'(stage_a.shift);
    b_sub    = stage_a.lo ? spin_sub_low : !spin_sub_low;

    stage_b_next      = '0;
    stage_b_next.ball = stage_a.ball;
    stage_b_next.lo   = stage_a.lo;
    stage_b_next.hi   = stage_a.hi;
    stage_b_next.mag  = stage_a.mag;
    stage_b_next.tbig = stage_a.tbig;
    stage_b_next.e    = b_escale[33:16];
    stage_b_next.tsum = b_sub ? (b_vt - b_sh) : (b_vt + b_sh);
  end

  always_comb begin
    c_efin  = (stage_b.tbig || (stage_b.e < wrs_pkg::E_FLOOR_Q16)) ?
              wrs_pkg::E_FLOOR_Q16 : stage_b.e;
    c_mprod = 50'(stage_b.mag) * 50'(c_efin);
    c_scale = wrs_pkg::TWO_Q16 - {1'b0, cfg.rail_friction};
    c_fprod = 53'(stage_b.tsum) * $signed({35'b0, c_scale});

    stage_c_next      = '0;
    stage_c_next.ball = stage_b.ball;
    stage_c_next.lo   = stage_b.lo;
    stage_c_next.hi   = stage_b.hi;
    stage_c_next.mag2 = c_mprod[48:16];
    stage_c_next.tnew = c_fprod[52:17];
  end

  always_comb begin
    stage_d_next      = '0;
    stage_d_next.ball = stage_c.ball;
    stage_d_next.lo   = stage_c.lo;
    stage_d_next.hi   = stage_c.hi;
    if (stage_c.lo) begin
      stage_d_next.ball.pos_n = $signed({16'b0, cfg.radius});
      stage_d_next.ball.vel_n = (|stage_c.mag2[32:31]) ? wrs_pkg::INT32_MAX :
                                $signed(stage_c.mag2[31:0]);
    end else if (stage_c.hi) begin
      stage_d_next.ball.pos_n = $signed({12'b0, limit} - {16'b0, cfg.radius});
      stage_d_next.ball.vel_n = (|stage_c.mag2[32:31]) ? wrs_pkg::INT32_MIN :
                                $signed(32'd0 - stage_c.mag2[31:0]);
    end
    if (stage_c.lo || stage_c.hi) begin
      stage_d_next.ball.vel_t = sat32(stage_c.tnew);
      stage_d_next.ball.hit   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
    end else begin
      if (ready_a) valid_a <= up_valid;
      if (ready_b) valid_b <= valid_a;
      if (ready_c) valid_c <= valid_b;
      if (ready_d) valid_d <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) stage_a <= stage_a_next;
    if (ready_b) stage_b <= stage_b_next;
    if (ready_c) stage_c <= stage_c_next;
    if (ready_d) stage_d <= stage_d_next;
  end

  assign dn_valid = valid_d;
  assign dn_ball  = stage_d.ball;

  `ASSERT_PROP(a_low_nonneg, valid_d && stage_d.lo |-> !stage_d.ball.vel_n[31] && !stage_d.ball.pos_n[31], "low wall rebound left a negative state")
  `ASSERT_PROP(a_high_inward, valid_d && stage_d.hi |-> stage_d.ball.vel_n[31] || stage_d.ball.vel_n == 32'sd0, "high wall rebound moves outward")
  `ASSERT_PROP(a_sunk_no_hit, valid_d && stage_d.ball.sunk |-> !stage_d.ball.hit, "sunk ball marked as bounced")

endmodule

`default_nettype wire

// ===== hw/rtl/wall_rebound_with_spin.sv =====
// Top level of the cushion rebound block: register file, x and y axis
// pipelines and the output register. Depends on wrs_pkg, wrs_cfg, wrs_axis.
`default_nettype none
`include "assert_macros.svh"

// Cushion rebound with spin exchange for one ball per transfer, in signed
// Q15.16 with saturation. The block takes one ball every clock cycle while
// the output is not stalled and passes it through four register stages for
// the x cushions, four for the y cushions (each stage holds at most one
// multiplier level), and one output register. The y stages see the values
// the x stages left. Stalls on the output back up stage by stage, so
// bubbles close up and nothing is lost or repeated. Configuration registers
// are written through the cfg port, which is always ready; write them only
// while no ball is in flight.
module wall_rebound_with_spin (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wrs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wrs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              pos_x,
  input  logic signed [31:0]              pos_y,
  input  logic signed [31:0]              vel_x,
  input  logic signed [31:0]              vel_y,
  input  logic signed [31:0]              spin_z,
  input  logic                            sunk,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              new_pos_x,
  output logic signed [31:0]              new_pos_y,
  output logic signed [31:0]              new_vel_x,
  output logic signed [31:0]              new_vel_y,
  output logic signed [31:0]              new_spin_z,
  output logic                            bounced
);

  wrs_pkg::cfg_t  regs;
  wrs_pkg::ball_t x_in, x_out, y_in, y_out, result;
  logic           x_ready, x_valid, y_ready, y_valid, out_ready;

  wrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  always_comb begin
    x_in.pos_n = pos_x;
    x_in.pos_o = pos_y;
    x_in.vel_n = vel_x;
    x_in.vel_t = vel_y;
    x_in.spin  = spin_z;
    x_in.hit   = 1'b0;
    x_in.sunk  = sunk;
  end

  wrs_axis u_axis_x (
    .clk          (clk),
    .rst          (rst),
    .spin_sub_low (1'b1),
    .limit        (regs.table_length),
    .cfg          (regs),
    .up_valid     (in_valid),
    .up_ready     (x_ready),
    .up_ball      (x_in),
    .dn_valid     (x_valid),
    .dn_ready     (y_ready),
    .dn_ball      (x_out)
  );

  always_comb begin
    y_in.pos_n = x_out.pos_o;
    y_in.pos_o = x_out.pos_n;
    y_in.vel_n = x_out.vel_t;
    y_in.vel_t = x_out.vel_n;
    y_in.spin  = x_out.spin;
    y_in.hit   = x_out.hit;
    y_in.sunk  = x_out.sunk;
  end

  wrs_axis u_axis_y (
    .clk          (clk),
    .rst          (rst),
    .spin_sub_low (1'b0),
    .limit        (regs.table_width),
    .cfg          (regs),
    .up_valid     (x_valid),
    .up_ready     (y_ready),
    .up_ball      (y_in),
    .dn_valid     (y_valid),
    .dn_ready     (out_ready),
    .dn_ball      (y_out)
  );

  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = !x_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= y_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) result <= y_out;
  end

  assign new_pos_x  = result.pos_o;
  assign new_pos_y  = result.pos_n;
  assign new_vel_x  = result.vel_t;
  assign new_vel_y  = result.vel_n;
  assign new_spin_z = result.spin;
  assign bounced    = result.hit;

  `ASSERT_PROP(a_stall_source, in_stall |-> out_valid && out_stall, "input stalled without a stalled output")
  `ASSERT_PROP(a_sunk_quiet, out_valid && result.sunk |-> !bounced, "sunk ball reported as bounced")
  `ASSERT_PROP(a_out_hold, out_valid && out_stall |=> out_valid && $stable(result), "stalled output transfer changed")

endmodule

`default_nettype wire
